// ===== rtl/mcob_pkg.sv =====
//------------------------------------------------------------------------------
// MP4 chunk offset builder package
// Shared widths, command and register codes, and the lookup query type
// that travels down the table cell chain.
//------------------------------------------------------------------------------
`default_nettype none

package mcob_pkg;

   localparam int DATA_W          = 32;
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int ENTRY_COUNT_W   = 7;
   localparam int ENTRY_INDEX_W   = 6;
   localparam int MAX_OPENINGS    = 64;
   localparam int OPEN_CNT_W      = $clog2(MAX_OPENINGS + 1);

   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DRAIN  = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT = 2'd2;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] chunk;
      logic [DATA_W-1:0] count;
   } query_type;

endpackage

`default_nettype wire

// ===== rtl/mcob_cell.sv =====
//------------------------------------------------------------------------------
// Sample-to-chunk table cell
// Holds one table entry and matches the lookup query passing through it
// against its own first chunk and its right neighbor's first chunk.
//------------------------------------------------------------------------------
`default_nettype none

module mcob_cell
   import mcob_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load_en,
   input  logic [DATA_W-1:0] load_first,
   input  logic [DATA_W-1:0] load_samples,
   input  logic              active,
   input  logic              last,
   input  logic [DATA_W-1:0] next_first,
   input  logic              up_valid,
   input  query_type         up_query,
   output logic [DATA_W-1:0] first,
   output logic              dn_valid,
   output query_type         dn_query
);

   logic [DATA_W-1:0] first_ff;
   logic [DATA_W-1:0] first_in;
   logic [DATA_W-1:0] samples_ff;
   logic [DATA_W-1:0] samples_in;
   logic              dn_valid_ff;
   logic              dn_valid_in;
   query_type         dn_query_ff;
   query_type         dn_query_in;
   logic              hit;

   assign hit = active && !up_query.found && (up_query.chunk >= first_ff) &&
                (last || (up_query.chunk < next_first));

   always_comb begin
      first_in          = load_en ? load_first : first_ff;
      samples_in        = load_en ? load_samples : samples_ff;
      dn_valid_in       = up_valid;
      dn_query_in       = up_query;
      dn_query_in.found = up_query.found | hit;
      if (hit) begin
         dn_query_in.count = samples_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else begin
         dn_valid_ff <= dn_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      samples_ff  <= samples_in;
      dn_query_ff <= dn_query_in;
   end

   assign first    = first_ff;
   assign dn_valid = dn_valid_ff;
   assign dn_query = dn_query_ff;

endmodule

`default_nettype wire

// ===== rtl/mp4_chunk_offset_builder.sv =====
//------------------------------------------------------------------------------
// MP4 chunk offset builder
// Rebuilds chunk offsets from a sample-to-chunk table held in a row of
// cells and a stream of sample sizes; one result item per chunk opening.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | cmd, entry fields, sample size
//   rsp     | out       | rsp_valid / rsp_ready | chunk number, offset, flags
//   csr     | in        | csr_write_en          | csr_index, csr_wdata
//
// Load and unused commands finish in the idle state; sample and drain pass a
// check step and, per chunk opened, a lookup (the query walks the whole cell
// chain, one cell a cycle) and a result step, the final chunk without lookup.
// One item is worked at a time; req_ready is high only while idle.
// Reset clears the run state and registers; table contents stay undefined.
// A low rsp_ready holds the block on the waiting result.
//------------------------------------------------------------------------------
`default_nettype none

module mp4_chunk_offset_builder
   import mcob_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic [ENTRY_INDEX_W-1:0] req_entry_index,
   input  logic [DATA_W-1:0]        req_entry_first_chunk,
   input  logic [DATA_W-1:0]        req_entry_samples,
   input  logic [DATA_W-1:0]        req_sample_size,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DATA_W-1:0]        rsp_chunk_number,
   output logic [DATA_W-1:0]        rsp_chunk_offset,
   output logic                     rsp_final_chunk,
   output logic                     rsp_more_pending,
   input  logic                     csr_write_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   localparam int CNT_W = ($clog2(TABLE_DEPTH + 1) > ENTRY_COUNT_W) ?
                          $clog2(TABLE_DEPTH + 1) : ENTRY_COUNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_LOOKUP,
      S_EVAL,
      S_SEND
   } state_type;

   state_type              state_ff,          state_in;
   logic [DATA_W-1:0]      base_offset_ff,    base_offset_in;
   logic [DATA_W-1:0]      chunk_count_ff,    chunk_count_in;
   logic [ENTRY_COUNT_W-1:0] entry_count_ff,  entry_count_in;
   logic [DATA_W-1:0]      next_chunk_ff,     next_chunk_in;
   logic [DATA_W-1:0]      samples_left_ff,   samples_left_in;
   logic [DATA_W-1:0]      running_offset_ff, running_offset_in;
   logic                   run_started_ff,    run_started_in;
   logic [OPEN_CNT_W-1:0]  opens_ff,          opens_in;
   logic                   is_sample_ff,      is_sample_in;
   logic [DATA_W-1:0]      size_ff,           size_in;
   logic                   rsp_valid_ff,      rsp_valid_in;
   logic [DATA_W-1:0]      rsp_number_ff,     rsp_number_in;
   logic [DATA_W-1:0]      rsp_offset_ff,     rsp_offset_in;
   logic                   rsp_final_ff,      rsp_final_in;
   logic                   rsp_more_ff,       rsp_more_in;

   logic                   can_open;
   logic                   cont;
   logic                   opens_full;
   logic                   open_fin;
   logic                   do_open;
   logic                   do_finish;
   logic                   inject_valid;
   logic                   load_accept;
   logic [CNT_W-1:0]       entry_count_ext;
   logic [CNT_W-1:0]       n_eff;

   logic                   chain_valid [TABLE_DEPTH+1];
   query_type              chain_query [TABLE_DEPTH+1];
   logic [DATA_W-1:0]      cell_first  [TABLE_DEPTH+1];

   assign req_ready  = (state_ff == S_IDLE);
   assign can_open   = run_started_ff && (next_chunk_ff <= chunk_count_ff);
   assign cont       = can_open && (!is_sample_ff || (samples_left_ff == '0));
   assign opens_full = (opens_ff == OPEN_CNT_W'(MAX_OPENINGS));
   assign open_fin   = (next_chunk_ff == chunk_count_ff);
   assign load_accept = req_valid && req_ready && (req_cmd == CMD_LOAD);

   assign entry_count_ext = CNT_W'(entry_count_ff);
   assign n_eff = (entry_count_ext > CNT_W'(TABLE_DEPTH)) ?
                  CNT_W'(TABLE_DEPTH) : entry_count_ext;

   assign chain_valid[0]       = inject_valid;
   assign chain_query[0].found = 1'b0;
   assign chain_query[0].chunk = next_chunk_ff;
   assign chain_query[0].count = '0;
   assign cell_first[TABLE_DEPTH] = '0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      mcob_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .load_en      (load_accept && (CNT_W'(req_entry_index) == CNT_W'(i))),
         .load_first   (req_entry_first_chunk),
         .load_samples (req_entry_samples),
         .active       (CNT_W'(i) < n_eff),
         .last         (CNT_W'(i + 1) >= n_eff),
         .next_first   (cell_first[i+1]),
         .up_valid     (chain_valid[i]),
         .up_query     (chain_query[i]),
         .first        (cell_first[i]),
         .dn_valid     (chain_valid[i+1]),
         .dn_query     (chain_query[i+1])
      );
   end

   always_comb begin
      state_in          = state_ff;
      base_offset_in    = base_offset_ff;
      chunk_count_in    = chunk_count_ff;
      entry_count_in    = entry_count_ff;
      next_chunk_in     = next_chunk_ff;
      samples_left_in   = samples_left_ff;
      running_offset_in = running_offset_ff;
      run_started_in    = run_started_ff;
      opens_in          = opens_ff;
      is_sample_in      = is_sample_ff;
      size_in           = size_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_number_in     = rsp_number_ff;
      rsp_offset_in     = rsp_offset_ff;
      rsp_final_in      = rsp_final_ff;
      rsp_more_in       = rsp_more_ff;
      do_open           = 1'b0;
      do_finish         = 1'b0;
      inject_valid      = 1'b0;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_BASE_OFFSET: base_offset_in = csr_wdata;
            CSR_CHUNK_COUNT: chunk_count_in = csr_wdata;
            CSR_ENTRY_COUNT: entry_count_in = csr_wdata[ENTRY_COUNT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && ((req_cmd == CMD_SAMPLE) || (req_cmd == CMD_DRAIN))) begin
               is_sample_in = (req_cmd == CMD_SAMPLE);
               size_in      = req_sample_size;
               opens_in     = '0;
               state_in     = S_CHECK;
               if (!run_started_ff) begin
                  run_started_in    = 1'b1;
                  running_offset_in = base_offset_ff;
                  next_chunk_in     = DATA_W'(1);
                  samples_left_in   = '0;
               end
            end
         end
         S_CHECK: begin
            if (cont) begin
               do_open = 1'b1;
            end else begin
               do_finish = 1'b1;
            end
         end
         S_LOOKUP: begin
            if (chain_valid[TABLE_DEPTH]) begin
               samples_left_in = chain_query[TABLE_DEPTH].count;
               state_in        = S_EVAL;
            end
         end
         S_EVAL: begin
            rsp_valid_in = 1'b1;
            rsp_more_in  = cont && opens_full;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (cont && !opens_full) begin
                  do_open = 1'b1;
               end else begin
                  do_finish = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (do_open) begin
         rsp_number_in = next_chunk_ff;
         rsp_offset_in = running_offset_ff;
         rsp_final_in  = open_fin;
         opens_in      = opens_ff + OPEN_CNT_W'(1);
         if (open_fin) begin
            next_chunk_in     = DATA_W'(1);
            samples_left_in   = '0;
            running_offset_in = '0;
            run_started_in    = 1'b0;
            state_in          = S_EVAL;
         end else begin
            next_chunk_in = next_chunk_ff + DATA_W'(1);
            inject_valid  = 1'b1;
            state_in      = S_LOOKUP;
         end
      end

      if (do_finish) begin
         if (is_sample_ff && run_started_ff && (samples_left_ff != '0)) begin
            running_offset_in = running_offset_ff + size_ff;
            samples_left_in   = samples_left_ff - DATA_W'(1);
         end
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         base_offset_ff    <= '0;
         chunk_count_ff    <= '0;
         entry_count_ff    <= '0;
         next_chunk_ff     <= DATA_W'(1);
         samples_left_ff   <= '0;
         running_offset_ff <= '0;
         run_started_ff    <= 1'b0;
         opens_ff          <= '0;
         is_sample_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         base_offset_ff    <= base_offset_in;
         chunk_count_ff    <= chunk_count_in;
         entry_count_ff    <= entry_count_in;
         next_chunk_ff     <= next_chunk_in;
         samples_left_ff   <= samples_left_in;
         running_offset_ff <= running_offset_in;
         run_started_ff    <= run_started_in;
         opens_ff          <= opens_in;
         is_sample_ff      <= is_sample_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      rsp_number_ff <= rsp_number_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_final_ff  <= rsp_final_in;
      rsp_more_ff   <= rsp_more_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chunk_number = rsp_number_ff;
   assign rsp_chunk_offset = rsp_offset_ff;
   assign rsp_final_chunk  = rsp_final_ff;
   assign rsp_more_pending = rsp_more_ff;

endmodule

`default_nettype wire

// ===== rtl/mcob_checker.sv =====
//------------------------------------------------------------------------------
// MP4 chunk offset builder checker
// Port-level assertions on the result channel and on req_ready, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module mcob_checker
   import mcob_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_chunk_number,
   input logic [DATA_W-1:0] rsp_chunk_offset,
   input logic              rsp_final_chunk,
   input logic              rsp_more_pending
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chunk_number) &&
      $stable(rsp_chunk_offset) && $stable(rsp_final_chunk) &&
      $stable(rsp_more_pending))
      else $error("rsp item changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("new item taken while a result waits");

   a_more_not_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_more_pending |-> !rsp_final_chunk)
      else $error("pending openings flagged on the final chunk");

   a_number_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chunk_number != '0))
      else $error("chunk number zero");

endmodule

bind mp4_chunk_offset_builder mcob_checker u_mcob_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_chunk_number (rsp_chunk_number),
   .rsp_chunk_offset (rsp_chunk_offset),
   .rsp_final_chunk  (rsp_final_chunk),
   .rsp_more_pending (rsp_more_pending)
);

`default_nettype wire

// ===== tb/sv/mcob_tb_pkg.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Chunk offset scoreboard
// Keeps its own copy of the sample-to-chunk table, the registers and the run
// state, works out the chunk offsets that each accepted item opens, and
// checks the emitted chunks against them in order.
//------------------------------------------------------------------------------
package mcob_tb_pkg;
   import mcob_pkg::*;

   typedef struct packed {
      bit [DATA_W-1:0] number;
      bit [DATA_W-1:0] offset;
      bit              fin;
      bit              more;
   } chunk_rec_type;

   class chunk_offset_board_type;
      bit [DATA_W-1:0]        first_tab [TABLE_DEPTH_DEF];
      bit [DATA_W-1:0]        spc_tab [TABLE_DEPTH_DEF];
      bit [DATA_W-1:0]        base;
      bit [DATA_W-1:0]        total;
      bit [ENTRY_COUNT_W-1:0] entries;
      bit [DATA_W-1:0]        next_chunk = 1;
      bit [DATA_W-1:0]        owed;
      bit [DATA_W-1:0]        offset;
      bit                     running;
      chunk_rec_type          due_chunks [$];
      int                     errors;

      function void set_regs(bit [DATA_W-1:0] b, bit [DATA_W-1:0] c,
                             bit [ENTRY_COUNT_W-1:0] e);
         base = b;
         total = c;
         entries = e;
      endfunction

      function void end_run();
         next_chunk = 1;
         owed = '0;
         offset = '0;
         running = 1'b0;
      endfunction

      function void start_run();
         if (!running) begin
            running = 1'b1;
            offset = base;
            next_chunk = 1;
            owed = '0;
         end
      endfunction

      function bit [DATA_W-1:0] samples_for(bit [DATA_W-1:0] c);
         int n;
         n = (entries > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(entries);
         for (int i = 0; i < n; i++)
            if (c >= first_tab[i] && (i + 1 >= n || c < first_tab[i + 1]))
               return spc_tab[i];
         return '0;
      endfunction

      function bit can_open();
         return running && next_chunk <= total;
      endfunction

      function void open_chunk();
         chunk_rec_type r;
         r.number = next_chunk;
         r.offset = offset;
         r.fin = (next_chunk == total);
         r.more = 1'b0;
         due_chunks.insert(due_chunks.size(), r);
         if (r.fin) begin
            end_run();
         end else begin
            owed = samples_for(next_chunk);
            next_chunk = next_chunk + 1;
         end
      endfunction

      function void flag_more();
         due_chunks[due_chunks.size() - 1].more = 1'b1;
      endfunction

      function void apply_item(bit [CMD_W-1:0] cmd, bit [ENTRY_INDEX_W-1:0] idx,
                               bit [DATA_W-1:0] first, bit [DATA_W-1:0] spc,
                               bit [DATA_W-1:0] size);
         int n;
         n = 0;
         if (cmd == CMD_LOAD) begin
            first_tab[idx] = first;
            spc_tab[idx] = spc;
         end else if (cmd == CMD_SAMPLE) begin
            start_run();
            while (owed == 0 && can_open() && n < MAX_OPENINGS) begin
               open_chunk();
               n++;
            end
            if (running && owed != 0) begin
               offset = offset + size;
               owed = owed - 1;
            end else if (owed == 0 && can_open() && n > 0) begin
               flag_more();
            end
         end else if (cmd == CMD_DRAIN) begin
            start_run();
            while (can_open() && n < MAX_OPENINGS) begin
               open_chunk();
               n++;
            end
            if (can_open() && n > 0)
               flag_more();
         end
      endfunction

      task report_mismatch(string msg);
         if (errors < 50)
            $display("%0t ERROR %s", $time, msg);
         errors++;
      endtask

      task check_chunk(logic [DATA_W-1:0] got_number, logic [DATA_W-1:0] got_offset,
                       logic got_fin, logic got_more);
         chunk_rec_type want;
         if (due_chunks.size() == 0) begin
            report_mismatch($sformatf("chunk %0d offset %h arrived with none due",
                                      got_number, got_offset));
            return;
         end
         want = due_chunks.pop_front();
         if (got_number !== want.number)
            report_mismatch($sformatf("chunk number %0d, due %0d", got_number, want.number));
         if (got_offset !== want.offset)
            report_mismatch($sformatf("chunk %0d offset %h, due %h",
                                      want.number, got_offset, want.offset));
         if (got_fin !== want.fin)
            report_mismatch($sformatf("chunk %0d final flag %b, due %b",
                                      want.number, got_fin, want.fin));
         if (got_more !== want.more)
            report_mismatch($sformatf("chunk %0d pending flag %b, due %b",
                                      want.number, got_more, want.more));
      endtask
   endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// MP4 chunk offset builder testbench
// Loads sample-to-chunk entries, streams sample sizes and drains with random
// gaps on both channels, rewrites the registers between phases and checks
// every emitted chunk offset against the scoreboard.
//------------------------------------------------------------------------------
module tb;
   import mcob_pkg::*;
   import mcob_tb_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES  = TABLE_DEPTH_DEF + 16;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd = CMD_LOAD;
   logic [ENTRY_INDEX_W-1:0] req_entry_index = '0;
   logic [DATA_W-1:0]        req_entry_first_chunk = '0;
   logic [DATA_W-1:0]        req_entry_samples = '0;
   logic [DATA_W-1:0]        req_sample_size = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [DATA_W-1:0]        rsp_chunk_number;
   logic [DATA_W-1:0]        rsp_chunk_offset;
   logic                     rsp_final_chunk;
   logic                     rsp_more_pending;
   logic                     csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = CSR_BASE_OFFSET;
   logic [DATA_W-1:0]        csr_wdata = '0;

   chunk_offset_board_type board;
   bit                     calm;
   bit                     loaded [TABLE_DEPTH_DEF];
   bit                     rsp_taken = 1'b0;
   int                     rsp_hold = 0;
   int                     quiet = 0;

   mp4_chunk_offset_builder uut (.*);

   always begin
      #4;
      clock = 1'b1;
      #4;
      clock = 1'b0;
   end

   function automatic int draw_gap();
      return calm ? 0 : int'($urandom_range(0, 19));
   endfunction

   function automatic int table_prefix();
      int p;
      p = 0;
      while (p < TABLE_DEPTH_DEF && loaded[p])
         p++;
      return p;
   endfunction

   function automatic logic [DATA_W-1:0] shaped_first(int slot);
      return (slot == 0) ? '0 : DATA_W'(2 * slot + 1);
   endfunction

   function automatic logic [DATA_W-1:0] draw_size();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   always @(negedge clock) begin
      if (rsp_taken)
         rsp_hold = draw_gap();
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_chunk(rsp_chunk_number, rsp_chunk_offset, rsp_final_chunk,
                              rsp_more_pending);
         if (req_valid && req_ready)
            board.apply_item(req_cmd, req_entry_index, req_entry_first_chunk,
                             req_entry_samples, req_sample_size);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("mp4_chunk_offset_builder verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ENTRY_INDEX_W-1:0] idx,
                            input logic [DATA_W-1:0] first, input logic [DATA_W-1:0] spc,
                            input logic [DATA_W-1:0] size);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_entry_index <= idx;
      req_entry_first_chunk <= first;
      req_entry_samples <= spc;
      req_sample_size <= size;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic load_entry(int slot, logic [DATA_W-1:0] first, logic [DATA_W-1:0] spc);
      loaded[slot] = 1'b1;
      send_item(CMD_LOAD, ENTRY_INDEX_W'(slot), first, spc, $urandom());
   endtask

   task automatic sample_item(logic [DATA_W-1:0] size);
      send_item(CMD_SAMPLE, ENTRY_INDEX_W'($urandom_range(0, 63)), $urandom(), $urandom(),
                size);
   endtask

   task automatic drain_item();
      send_item(CMD_DRAIN, ENTRY_INDEX_W'($urandom_range(0, 63)), $urandom(), $urandom(),
                $urandom());
   endtask

   task automatic settle();
      while (board.due_chunks.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic reconfigure(logic [DATA_W-1:0] base_value, logic [DATA_W-1:0] count_value,
                              logic [ENTRY_COUNT_W-1:0] entry_value);
      req_valid <= 1'b0;
      settle();
      csr_write_en <= 1'b1;
      csr_index <= CSR_BASE_OFFSET;
      csr_wdata <= base_value;
      @(negedge clock);
      csr_index <= CSR_CHUNK_COUNT;
      csr_wdata <= count_value;
      @(negedge clock);
      csr_index <= CSR_ENTRY_COUNT;
      csr_wdata <= DATA_W'(entry_value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      board.set_regs(base_value, count_value, entry_value);
      calm = ($urandom_range(0, 3) == 0);
   endtask

   task automatic directed_part();
      // zero chunk count: run starts but nothing opens
      sample_item('1);
      drain_item();
      send_item(CMD_UNUSED, '1, '1, '1, '1);
      load_entry(0, '0, 2);
      load_entry(1, shaped_first(1), 1);
      load_entry(2, shaped_first(2), '0);
      load_entry(3, shaped_first(3), '1);
      load_entry(TABLE_DEPTH_DEF - 1, '1, '0);

      reconfigure(32'hFFFF_FFF0, 8, 4);
      sample_item('1);
      sample_item('0);
      sample_item(32'h8000_0000);
      sample_item(32'h8000_0000);
      repeat (4) sample_item($urandom());
      drain_item();

      // endless run: openings stop at the cap and stay pending
      reconfigure('0, '1, '0);
      drain_item();
      drain_item();
      sample_item($urandom());
      reconfigure($urandom(), board.next_chunk + 2, 4);
      drain_item();
   endtask

   task automatic random_part();
      logic [DATA_W-1:0] count_value;
      logic [DATA_W-1:0] base_value;
      int                entry_value;
      int                slot;
      int                prefix;
      int                pick;
      int                ph;
      for (ph = 0; ph < 5; ph++) begin
         prefix = table_prefix();
         if (ph == 3) begin
            for (slot = prefix; slot < TABLE_DEPTH_DEF; slot++)
               load_entry(slot, shaped_first(slot), $urandom_range(0, 3));
            prefix = TABLE_DEPTH_DEF;
         end

         if (board.running && $urandom_range(0, 3) == 0)
            count_value = board.next_chunk - 1;
         else if (board.running)
            count_value = board.next_chunk + $urandom_range(0, 10);
         else if ($urandom_range(0, 7) == 0)
            count_value = '0;
         else
            count_value = $urandom_range(1, 12);

         case ($urandom_range(0, 3))
            0: base_value = '0;
            1: base_value = '1;
            2: base_value = 32'hFFFF_FF00 | $urandom_range(0, 255);
            default: base_value = $urandom();
         endcase

         if (ph == 3 || $urandom_range(0, 3) == 0)
            entry_value = prefix;
         else
            entry_value = $urandom_range(0, prefix);
         reconfigure(base_value, count_value, ENTRY_COUNT_W'(entry_value));

         repeat ($urandom_range(3, 7)) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               sample_item(draw_size());
            end else if (pick < 80) begin
               slot = $urandom_range(0, (prefix < TABLE_DEPTH_DEF) ? prefix
                                                                   : TABLE_DEPTH_DEF - 1);
               load_entry(slot, shaped_first(slot), $urandom_range(0, 3));
               prefix = table_prefix();
            end else if (pick < 85) begin
               load_entry($urandom_range(0, TABLE_DEPTH_DEF - 1), $urandom(), $urandom());
               prefix = table_prefix();
            end else if (pick < 90) begin
               send_item(CMD_UNUSED, ENTRY_INDEX_W'($urandom_range(0, 63)), $urandom(),
                         $urandom(), $urandom());
            end else begin
               drain_item();
            end
         end
         if ($urandom_range(0, 3) != 0)
            drain_item();
      end
   endtask

   initial begin
      board = new;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      directed_part();
      random_part();
      req_valid <= 1'b0;
      settle();
      if (board.errors == 0 && board.due_chunks.size() == 0)
         $display("mp4_chunk_offset_builder verification clean");
      else
         $display("mp4_chunk_offset_builder verification failed");
      $finish;
   end

endmodule
